// File: hdl/lud_pkg.sv
// Package for the LU decomposition engine (unit-diagonal lower factor).
// Holds request and status codes, default parameter values and the sequencer state type.
// No dependencies.
package lud_pkg;

    localparam int MAX_ORDER_DEF     = 64;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [1:0] REQ_LOAD = 2'd0;
    localparam logic [1:0] REQ_RUN  = 2'd1;
    localparam logic [1:0] REQ_READ = 2'd2;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_ZERO_PIVOT = 2'd1;
    localparam logic [1:0] ST_SATURATED  = 2'd2;
    localparam logic [1:0] ST_RANGE      = 2'd3;

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_ISSUE  = 8'b0000_0100,
        S_LOAD   = 8'b0000_1000,
        S_MAC    = 8'b0001_0000,
        S_DIV    = 8'b0010_0000,
        S_DIVEND = 8'b0100_0000,
        S_FINISH = 8'b1000_0000
    } state_t;

endpackage

// File: hdl/lu_decompose_unit_lower_core.sv
// LU decomposition engine, Doolittle scheme, top level.
// Depends on lud_pkg; holds the source and factor memories and the run sequencer.
// Load and read requests are taken one per cycle unless the output path stalls; their result
// beat passes through a pending stage and an output register. A run request first clears the
// N x N factor region, then computes each factor entry on one shared multiplier fed by the
// two read ports of the factor memory; every entry below the diagonal also passes through the
// bit-serial divider. No request is taken while a run is in progress; its result beat carries
// the run status.
module lu_decompose_unit_lower_core
    import lud_pkg::*;
#(
    parameter int MAX_ORDER     = MAX_ORDER_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         req_type,
    input  logic [5:0]         row_index,
    input  logic [5:0]         col_index,
    input  logic signed [31:0] entry_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] lower_value,
    output logic signed [31:0] upper_value,
    output logic [1:0]         status
);

    localparam int DEPTH = MAX_ORDER * MAX_ORDER;
    localparam int AW    = $clog2(DEPTH);
    localparam int IW    = $clog2(MAX_ORDER);
    localparam int CW    = $clog2(MAX_ORDER + 1);
    localparam int DW    = 32 + FRACTION_BITS;
    localparam int DCW   = $clog2(DW);

    logic signed [31:0] src_mem [DEPTH];
    logic signed [31:0] fac_mem [DEPTH];

    state_t state_reg, state_next;

    logic [6:0]    size_reg;
    logic [1:0]    run_status_reg;
    logic [1:0]    fin_status_reg;
    logic [IW-1:0] i_reg, j_reg, k_reg;
    logic          phase_low_reg;
    logic          v1_reg, v2_reg;
    logic          sat_reg;
    logic [DCW-1:0] cnt_reg;

    logic signed [31:0] fa_q, fb_q, src_q;
    logic signed [63:0] prod_reg;
    logic signed [31:0] acc_reg, pivot_reg;
    logic [31:0]        rem_reg, den_reg;
    logic [DW-1:0]      quo_reg;
    logic               neg_reg;

    logic       p_valid_reg, p_read_reg;
    logic [1:0] p_status_reg;
    logic [5:0] p_row_reg, p_col_reg;

    logic               out_valid_reg;
    logic signed [31:0] lower_reg, upper_reg;
    logic [1:0]         status_reg;

    logic [CW-1:0] n_use, i_inc, j_inc;
    logic          in_range, accept, out_free, p_free, p_move;
    logic [AW-1:0] req_addr, cell_addr, a_addr, b_addr;
    logic [IW-1:0] er, ec;
    logic          mac_issue, mac_done, clear_last, div_last;
    logic signed [31:0] piv_now;
    logic signed [63:0] qprod, diff;
    logic signed [31:0] diff_clamped;
    logic               diff_sat;
    logic [32:0]        rem_sh;
    logic               rem_ge;
    logic [31:0]        acc_mag, piv_mag;
    logic [DW-1:0]      quo_neg;
    logic signed [31:0] div_res;
    logic               div_sat;
    logic               we;
    logic signed [31:0] wdata;
    logic [1:0]         acc_status;
    logic signed [31:0] rd_lower, rd_upper;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {25'd0, size_reg} : 32'd0;

    always_comb
    begin
        if (size_reg == 7'd0)
        begin
            n_use = CW'(1);
        end
        else if ({1'b0, size_reg} > 8'(MAX_ORDER))
        begin
            n_use = CW'(MAX_ORDER);
        end
        else
        begin
            n_use = CW'(size_reg);
        end
    end

    assign i_inc    = CW'(i_reg) + CW'(1);
    assign j_inc    = CW'(j_reg) + CW'(1);
    assign in_range = ({2'b00, row_index} < 8'(n_use)) && ({2'b00, col_index} < 8'(n_use));

    assign out_free = !out_valid_reg || !out_stall;
    assign p_free   = !p_valid_reg || out_free;
    assign p_move   = p_valid_reg && out_free;
    assign in_stall = (state_reg != S_IDLE) || !p_free;
    assign accept   = in_valid && !in_stall;

    assign er = phase_low_reg ? j_reg : i_reg;
    assign ec = phase_low_reg ? i_reg : j_reg;

    assign req_addr  = AW'(row_index) * AW'(MAX_ORDER) + AW'(col_index);
    assign cell_addr = AW'(er) * AW'(MAX_ORDER) + AW'(ec);
    assign a_addr    = (state_reg == S_IDLE) ? req_addr
                                             : AW'(er) * AW'(MAX_ORDER) + AW'(k_reg);
    assign b_addr    = AW'(k_reg) * AW'(MAX_ORDER) + AW'(ec);

    assign mac_issue  = (state_reg == S_MAC) && (k_reg < i_reg);
    assign mac_done   = (state_reg == S_MAC) && !(k_reg < i_reg) && !v1_reg && !v2_reg;
    assign clear_last = (i_inc == n_use) && (j_inc == n_use);
    assign div_last   = (cnt_reg == DCW'(DW - 1));
    assign piv_now    = (j_reg == i_reg) ? acc_reg : pivot_reg;

    assign qprod = prod_reg >>> FRACTION_BITS;
    assign diff  = 64'(acc_reg) - qprod;

    always_comb
    begin
        diff_sat = 1'b0;
        if (diff > 64'sd2147483647)
        begin
            diff_clamped = 32'sh7FFF_FFFF;
            diff_sat     = 1'b1;
        end
        else if (diff < -64'sd2147483648)
        begin
            diff_clamped = 32'sh8000_0000;
            diff_sat     = 1'b1;
        end
        else
        begin
            diff_clamped = diff[31:0];
        end
    end

    assign acc_mag = acc_reg[31] ? 32'(-acc_reg) : 32'(acc_reg);
    assign piv_mag = pivot_reg[31] ? 32'(-pivot_reg) : 32'(pivot_reg);
    assign rem_sh  = {rem_reg, quo_reg[DW-1]};
    assign rem_ge  = rem_sh >= {1'b0, den_reg};
    assign quo_neg = DW'(0) - quo_reg;

    always_comb
    begin
        div_sat = 1'b0;
        if (!neg_reg && (quo_reg > DW'(64'h7FFF_FFFF)))
        begin
            div_res = 32'sh7FFF_FFFF;
            div_sat = 1'b1;
        end
        else if (neg_reg && (quo_reg > DW'(64'h8000_0000)))
        begin
            div_res = 32'sh8000_0000;
            div_sat = 1'b1;
        end
        else if (neg_reg)
        begin
            div_res = quo_neg[31:0];
        end
        else
        begin
            div_res = quo_reg[31:0];
        end
    end

    assign we    = (state_reg == S_CLEAR) || (mac_done && !phase_low_reg)
                   || (state_reg == S_DIVEND);
    assign wdata = (state_reg == S_CLEAR) ? 32'sd0
                 : (state_reg == S_DIVEND) ? div_res : acc_reg;

    always_comb
    begin
        acc_status = ST_OK;
        case (req_type)
            REQ_LOAD: acc_status = in_range ? ST_OK : ST_RANGE;
            REQ_READ: acc_status = in_range ? run_status_reg : ST_RANGE;
            default:  acc_status = ST_OK;
        endcase
    end

    always_comb
    begin
        rd_lower = 32'sd0;
        rd_upper = 32'sd0;
        if (p_read_reg)
        begin
            if (p_row_reg == p_col_reg)
            begin
                rd_lower = 32'sd1 <<< FRACTION_BITS;
            end
            else if (p_row_reg > p_col_reg)
            begin
                rd_lower = fa_q;
            end
            if (p_col_reg >= p_row_reg)
            begin
                rd_upper = fa_q;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (req_type == REQ_RUN))
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                if (clear_last)
                begin
                    state_next = S_ISSUE;
                end
            end
            S_ISSUE:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                state_next = S_MAC;
            end
            S_MAC:
            begin
                if (mac_done)
                begin
                    if (phase_low_reg)
                    begin
                        state_next = S_DIV;
                    end
                    else if (j_inc < n_use)
                    begin
                        state_next = S_ISSUE;
                    end
                    else if ((piv_now == 32'sd0) || !(i_inc < n_use))
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
            end
            S_DIV:
            begin
                if (div_last)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                state_next = S_ISSUE;
            end
            S_FINISH:
            begin
                if (p_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && (req_type == REQ_LOAD) && in_range)
        begin
            src_mem[req_addr] <= entry_value;
        end
        if (state_reg == S_ISSUE)
        begin
            src_q <= src_mem[cell_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            fac_mem[cell_addr] <= wdata;
        end
        if ((accept && (req_type == REQ_READ)) || mac_issue)
        begin
            fa_q <= fac_mem[a_addr];
        end
        if (mac_issue)
        begin
            fb_q <= fac_mem[b_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= 64'(fa_q) * 64'(fb_q);
        end
        if (state_reg == S_LOAD)
        begin
            acc_reg <= src_q;
        end
        else if (v2_reg)
        begin
            acc_reg <= diff_clamped;
        end
        if (mac_done && !phase_low_reg && (j_reg == i_reg))
        begin
            pivot_reg <= acc_reg;
        end
        if (mac_done && phase_low_reg)
        begin
            rem_reg <= 32'd0;
            quo_reg <= {acc_mag, FRACTION_BITS'(0)};
            den_reg <= piv_mag;
            neg_reg <= acc_reg[31] ^ pivot_reg[31];
        end
        else if (state_reg == S_DIV)
        begin
            rem_reg <= rem_ge ? 32'(rem_sh - {1'b0, den_reg}) : rem_sh[31:0];
            quo_reg <= {quo_reg[DW-2:0], rem_ge};
        end
        if (p_move)
        begin
            lower_reg  <= rd_lower;
            upper_reg  <= rd_upper;
            status_reg <= p_status_reg;
        end
        if (accept)
        begin
            p_row_reg    <= row_index;
            p_col_reg    <= col_index;
            p_read_reg   <= (req_type == REQ_READ) && in_range;
            p_status_reg <= acc_status;
        end
        else if ((state_reg == S_FINISH) && p_free)
        begin
            p_read_reg   <= 1'b0;
            p_status_reg <= fin_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            size_reg       <= 7'(MAX_ORDER);
            run_status_reg <= ST_OK;
            fin_status_reg <= ST_OK;
            i_reg          <= '0;
            j_reg          <= '0;
            k_reg          <= '0;
            phase_low_reg  <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            sat_reg        <= 1'b0;
            cnt_reg        <= '0;
            p_valid_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (psel && penable && pwrite && pready && (paddr[2] == 1'b0))
            begin
                size_reg <= pwdata[6:0];
            end

            v1_reg <= mac_issue;
            v2_reg <= v1_reg;
            if (v2_reg && diff_sat)
            begin
                sat_reg <= 1'b1;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (accept && (req_type == REQ_RUN))
                    begin
                        i_reg         <= '0;
                        j_reg         <= '0;
                        phase_low_reg <= 1'b0;
                        sat_reg       <= 1'b0;
                    end
                end
                S_CLEAR:
                begin
                    if (j_inc == n_use)
                    begin
                        j_reg <= '0;
                        i_reg <= clear_last ? '0 : IW'(i_inc);
                    end
                    else
                    begin
                        j_reg <= IW'(j_inc);
                    end
                end
                S_LOAD:
                begin
                    k_reg <= '0;
                end
                S_MAC:
                begin
                    if (mac_issue)
                    begin
                        k_reg <= k_reg + IW'(1);
                    end
                    if (mac_done && !phase_low_reg)
                    begin
                        if (j_inc < n_use)
                        begin
                            j_reg <= IW'(j_inc);
                        end
                        else if (piv_now == 32'sd0)
                        begin
                            fin_status_reg <= ST_ZERO_PIVOT;
                        end
                        else if (i_inc < n_use)
                        begin
                            phase_low_reg <= 1'b1;
                            j_reg         <= IW'(i_inc);
                        end
                        else
                        begin
                            fin_status_reg <= (sat_reg || (v2_reg && diff_sat))
                                              ? ST_SATURATED : ST_OK;
                        end
                    end
                    if (mac_done && phase_low_reg)
                    begin
                        cnt_reg <= '0;
                    end
                end
                S_DIV:
                begin
                    cnt_reg <= cnt_reg + DCW'(1);
                end
                S_DIVEND:
                begin
                    if (div_sat)
                    begin
                        sat_reg <= 1'b1;
                    end
                    if (j_inc < n_use)
                    begin
                        j_reg <= IW'(j_inc);
                    end
                    else
                    begin
                        i_reg         <= IW'(i_inc);
                        j_reg         <= IW'(i_inc);
                        phase_low_reg <= 1'b0;
                    end
                end
                S_FINISH:
                begin
                    if (p_free)
                    begin
                        run_status_reg <= fin_status_reg;
                    end
                end
                default:
                begin
                end
            endcase

            if ((accept && (req_type != REQ_RUN)) || ((state_reg == S_FINISH) && p_free))
            begin
                p_valid_reg <= 1'b1;
            end
            else if (p_move)
            begin
                p_valid_reg <= 1'b0;
            end

            if (p_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign lower_value = lower_reg;
    assign upper_value = upper_reg;
    assign status      = status_reg;

endmodule
